/* hdl/tkct_pkg.sv */
// package for the top-k cost tracker: sizes, request codes and the record,
// request, result and slot memory access types
// no dependencies

package tkct_pkg;

    // number of records held, and widths that follow from it
    localparam int KEEP_COUNT = 16;
    localparam int IDX_W      = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int CNT_W      = $clog2(KEEP_COUNT + 1);

    // fixed field widths
    localparam int ID_W    = 32;
    localparam int LEVEL_W = 16;
    localparam int COST_W  = 32;
    localparam int RIDX_W  = 4;
    localparam int POS_W   = 4;
    localparam int LCNT_W  = 5;
    localparam int CMP_W   = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    // request codes carried in tuser
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ID_W-1:0]    parent;
        logic [LEVEL_W-1:0] level;
        logic [COST_W-1:0]  cost;
    } t_rec;

    typedef struct packed {
        logic [1:0]        req_type;
        t_rec              rec;
        logic [RIDX_W-1:0] read_index;
    } t_req;

    typedef struct packed {
        logic              kept;
        logic [POS_W-1:0]  kept_position;
        logic              entry_valid;
        t_rec              entry;
        logic [LCNT_W-1:0] list_count;
    } t_result;

    // one write and one read address per cycle into the slot store
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_rec             wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

/* hdl/tkct_store.sv */
// slot store of the top-k cost tracker: one record per slot, one write port
// and one registered read port; depends on tkct_pkg

module tkct_store (
    input  logic               i_clk,
    input  tkct_pkg::t_mem_req i_mem,
    output tkct_pkg::t_rec     o_rd_data
);
    import tkct_pkg::*;

    t_rec r_mem [KEEP_COUNT];
    t_rec r_rd_data;

    // write and registered read, no reset on contents
    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
        r_rd_data <= r_mem[i_mem.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/tkct_ctrl.sv */
// request sequencer of the top-k cost tracker: walks the list from the bottom
// slot upwards, one compare and one slot move a cycle; depends on tkct_pkg

module tkct_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tkct_pkg::t_req     i_req,
    output logic               o_idle,
    input  logic               i_res_ready,
    output logic               o_res_valid,
    output tkct_pkg::t_result  o_res,
    output tkct_pkg::t_mem_req o_mem,
    input  tkct_pkg::t_rec     i_rd_data
);
    import tkct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SHIFT,
        S_PLACE,
        S_RDWAIT,
        S_DONE
    } t_state;

    t_state             r_state;
    t_req               r_req;
    t_result            r_res;
    logic               r_res_valid;
    logic [CNT_W-1:0]   r_count;
    logic [COST_W-1:0]  r_lowest;
    logic [IDX_W-1:0]   r_hole;
    logic [IDX_W-1:0]   r_last;

    logic               full;
    logic [IDX_W-1:0]   last_pos;
    logic               shift_go;
    logic               idx_hit;
    logic               reject;

    // list status
    assign full     = (r_count >= CNT_W'(KEEP_COUNT));
    assign last_pos = full ? IDX_W'(KEEP_COUNT - 1) : IDX_W'(r_count);
    assign idx_hit  = (CMP_W'(r_req.read_index) < CMP_W'(r_count));
    assign reject   = (r_req.rec.cost == '0) || (full && (r_req.rec.cost <= r_lowest));

    // shared compare: stored record above the hole is strictly cheaper
    assign shift_go = (i_rd_data.cost < r_req.rec.cost);

    // slot store access
    always_comb begin
        o_mem = '0;
        unique case (r_state)
            S_START: begin
                if (r_req.req_type == REQ_INSERT) begin
                    o_mem.raddr = last_pos - IDX_W'(1);
                end else begin
                    o_mem.raddr = IDX_W'(r_req.read_index);
                end
            end
            S_SHIFT: begin
                o_mem.raddr = r_hole - IDX_W'(2);
                o_mem.we    = shift_go;
                o_mem.waddr = r_hole;
                o_mem.wdata = i_rd_data;
            end
            S_PLACE: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_hole;
                o_mem.wdata = r_req.rec;
            end
            default: begin
                o_mem = '0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_lowest    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_res <= '0;
                    unique case (r_req.req_type)
                        REQ_INSERT: begin
                            if (reject) begin
                                r_state <= S_DONE;
                            end else begin
                                r_last  <= last_pos;
                                r_hole  <= last_pos;
                                r_state <= (last_pos == '0) ? S_PLACE : S_SHIFT;
                            end
                        end
                        REQ_READ: begin
                            r_state <= idx_hit ? S_RDWAIT : S_DONE;
                        end
                        REQ_CLEAR: begin
                            r_count  <= '0;
                            r_lowest <= '0;
                            r_state  <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_SHIFT: begin
                    if (shift_go) begin
                        // record moved into the bottom slot is the new minimum
                        if (r_hole == r_last) begin
                            r_lowest <= i_rd_data.cost;
                        end
                        r_hole <= r_hole - IDX_W'(1);
                        if (r_hole == IDX_W'(1)) begin
                            r_state <= S_PLACE;
                        end
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_res.kept          <= 1'b1;
                    r_res.kept_position <= POS_W'(r_hole);
                    if (r_hole == r_last) begin
                        r_lowest <= r_req.rec.cost;
                    end
                    if (!full) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_RDWAIT: begin
                    r_res.entry_valid <= 1'b1;
                    r_res.entry       <= i_rd_data;
                    r_state           <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_res.list_count <= LCNT_W'(r_count);
                        r_res_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* hdl/top_k_cost_tracker_core.sv */
// top level of the top-k cost tracker: stream ports, output register,
// sequencer and slot store; depends on tkct_pkg, tkct_ctrl, tkct_store
//
// keeps the KEEP_COUNT highest-cost records sorted from high to low cost.
// s_axis carries one request per beat: tuser holds the request type (insert,
// read, clear), tdata the record and the read index. m_axis returns exactly
// one result beat per request: kept flag and position for an insert, the
// entry for a read, and always the list count after the request.
// states from the accept edge to the result in the output register:
//   insert: start, walk, place, done; the walk is skipped on an empty list
//           and moves each cheaper record down one slot, stopping at the
//           first record that is not cheaper or once the top slot is moved
//   rejected insert, read beyond the count, clear, unused codes: start, done
//   read of a held entry: start, read wait, done
// the insert walk compares and moves one slot per cycle through the one read
// and one write port of the slot store, which sets the insert time.
// s_axis_tready is high only while the sequencer is idle and out of reset, so
// one request is in work at a time; the next request can be taken at the
// edge that loads the output register.
// a stalled m_axis holds its result; a finished request waits in the
// sequencer until the output register is free. reset empties the list; slot
// contents are not cleared, as only slots below the count are ever used.

module top_k_cost_tracker_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // rec_id[31:0], rec_parent[63:32], rec_level[79:64], rec_cost[111:80],
    // read_index[115:112], zero pad [119:116]
    input  logic [119:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kept[0], kept_position[4:1], entry_valid[5], entry_id[37:6],
    // entry_parent[69:38], entry_level[85:70], entry_cost[117:86],
    // list_count[122:118], zero pad [127:123]
    output logic [127:0] m_axis_tdata
);
    import tkct_pkg::*;

    t_req     in_req;
    logic     idle;
    logic     start;
    logic     res_valid;
    t_result  res;
    t_mem_req mem_req;
    t_rec     rd_data;
    logic     r_m_tvalid;
    t_result  r_m_res;

    // unpack the request beat
    always_comb begin
        in_req.req_type   = s_axis_tuser;
        in_req.rec.id     = s_axis_tdata[31:0];
        in_req.rec.parent = s_axis_tdata[63:32];
        in_req.rec.level  = s_axis_tdata[79:64];
        in_req.rec.cost   = s_axis_tdata[111:80];
        in_req.read_index = s_axis_tdata[115:112];
    end

    assign s_axis_tready = idle && i_rst_n;
    assign start         = s_axis_tvalid && s_axis_tready;

    tkct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (in_req),
        .o_idle      (idle),
        .i_res_ready (!r_m_tvalid || m_axis_tready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data)
    );

    tkct_store u_store (
        .i_clk     (i_clk),
        .i_mem     (mem_req),
        .o_rd_data (rd_data)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res_valid) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {5'd0, r_m_res.list_count, r_m_res.entry.cost,
                            r_m_res.entry.level, r_m_res.entry.parent,
                            r_m_res.entry.id, r_m_res.entry_valid,
                            r_m_res.kept_position, r_m_res.kept};

endmodule

/* hdl/tkct_checker.sv */
// port checker for the top-k cost tracker, bound to the top level;
// depends on tkct_pkg and top_k_cost_tracker_core

module tkct_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    import tkct_pkg::*;

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // one request in work: no accept on the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in work");

    // count never exceeds the list size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[122:118] <= LCNT_W'(KEEP_COUNT)))
        else $error("list count above list size");

    // a kept record lies inside the list, and an insert never also reads
    a_kept_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |->
            ((m_axis_tdata[4:1] < m_axis_tdata[122:118]) && !m_axis_tdata[5]))
        else $error("kept position outside the list");

endmodule

bind top_k_cost_tracker_core tkct_checker u_tkct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* dv/tb_top.sv */
// testbench for top_k_cost_tracker_core: directed requests, then random traffic,
// each result checked against a fixed expected value or a behavioural model of
// the sorted top-k list; depends on tkct_pkg and the top_k_cost_tracker_core rtl

`timescale 1ns / 1ps

module tb_top;
    import tkct_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 100;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        t_req    req;
        bit      typed;
        t_result want;
    } t_stim_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // rec_id[31:0], rec_parent[63:32], rec_level[79:64], rec_cost[111:80],
    // read_index[115:112], zero pad [119:116]
    logic [119:0] s_axis_tdata;
    // req_type[1:0]
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // kept[0], kept_position[4:1], entry_valid[5], entry_id[37:6],
    // entry_parent[69:38], entry_level[85:70], entry_cost[117:86],
    // list_count[122:118], zero pad [127:123]
    logic [127:0] m_axis_tdata;

    // model state of the sorted list
    t_rec        list_slot [KEEP_COUNT];
    int          list_held;
    logic [31:0] list_lowest;

    t_result   pending_results[$];
    t_stim_row stim_rows[$];
    int        fail_count = 0;
    int        sender_idle_pct;
    int        recv_stall_pct;
    bit        hold_request;
    int        quiet_cycles;

    top_k_cost_tracker_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // model of one request: updates the list and returns the result beat
    function automatic t_result track_request(t_req r);
        t_result res;
        int      pos;
        int      last;
        int      j;
        res = '0;
        case (r.req_type)
            REQ_INSERT: begin
                if (r.rec.cost != 0) begin
                    if (list_held == 0) begin
                        list_slot[0] = r.rec;
                        list_held    = 1;
                        list_lowest  = r.rec.cost;
                        res.kept     = 1'b1;
                    end else if (r.rec.cost <= list_lowest) begin
                        // append at the tail only while there is room
                        if (list_held < KEEP_COUNT) begin
                            list_slot[list_held] = r.rec;
                            res.kept             = 1'b1;
                            res.kept_position    = POS_W'(list_held);
                            list_held++;
                            list_lowest = r.rec.cost;
                        end
                    end else begin
                        // first slot of strictly lower cost, ties stay ahead
                        pos = 0;
                        while (pos < list_held && r.rec.cost <= list_slot[pos].cost)
                            pos++;
                        last = (list_held >= KEEP_COUNT) ? KEEP_COUNT - 1 : list_held;
                        for (j = last; j > pos; j--)
                            list_slot[j] = list_slot[j-1];
                        list_slot[pos] = r.rec;
                        if (list_held < KEEP_COUNT)
                            list_held++;
                        list_lowest       = list_slot[list_held-1].cost;
                        res.kept          = 1'b1;
                        res.kept_position = POS_W'(pos);
                    end
                end
            end
            REQ_READ: begin
                if (r.read_index < list_held) begin
                    res.entry_valid = 1'b1;
                    res.entry       = list_slot[r.read_index];
                end
            end
            REQ_CLEAR: begin
                list_held   = 0;
                list_lowest = '0;
            end
            default: ;
        endcase
        res.list_count = LCNT_W'(list_held);
        return res;
    endfunction

    function automatic t_req make_req(logic [1:0] kind, logic [31:0] id, logic [31:0] parent,
                                      logic [15:0] level, logic [31:0] cost,
                                      logic [3:0] idx);
        t_req r;
        r.req_type   = kind;
        r.rec.id     = id;
        r.rec.parent = parent;
        r.rec.level  = level;
        r.rec.cost   = cost;
        r.read_index = idx;
        return r;
    endfunction

    // result with no entry, for rows whose outcome is plain
    function automatic t_result plain_result(int kept, int pos, int count);
        t_result res;
        res               = '0;
        res.kept          = (kept != 0);
        res.kept_position = POS_W'(pos);
        res.list_count    = LCNT_W'(count);
        return res;
    endfunction

    task automatic add_row(t_req r, int typed, t_result want);
        t_stim_row row;
        row.req   = r;
        row.typed = (typed != 0);
        row.want  = want;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    // random request: mostly inserts and reads, some clears and unused codes
    function automatic t_req random_req();
        t_req        r;
        int          sel;
        int          csel;
        logic [31:0] cost;
        sel  = $urandom_range(0, 99);
        csel = $urandom_range(0, 99);
        if (csel < 40)
            cost = $urandom;
        else if (csel < 80)
            cost = $urandom_range(1, 24);
        else if (csel < 90)
            cost = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        else
            cost = '0;
        r = make_req(REQ_INSERT, $urandom, $urandom, 16'($urandom_range(0, 65535)), cost,
                     4'($urandom_range(0, 15)));
        if (sel >= 97)
            r.rec.cost = '0;
        else if (sel >= 93)
            r.req_type = REQ_UNUSED;
        else if (sel >= 90)
            r.req_type = REQ_CLEAR;
        else if (sel >= 65)
            r.req_type = REQ_READ;
        return r;
    endfunction

    // offer one request beat, then record what it should return
    task automatic send_req(t_req r, bit typed, t_result want);
        t_result res;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, r.read_index, r.rec.cost, r.rec.level, r.rec.parent,
                          r.rec.id};
        s_axis_tuser  <= r.req_type;
        do @(posedge i_clk); while (!s_axis_tready);
        res = track_request(r);
        pending_results.insert(pending_results.size(), typed ? want : res);
    endtask

    task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // compare each result beat with the oldest outstanding one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %0h", $time,
                         m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                match_field("kept", 32'(want.kept), 32'(m_axis_tdata[0]));
                match_field("kept_position", 32'(want.kept_position),
                            32'(m_axis_tdata[4:1]));
                match_field("entry_valid", 32'(want.entry_valid), 32'(m_axis_tdata[5]));
                match_field("entry_id", want.entry.id, m_axis_tdata[37:6]);
                match_field("entry_parent", want.entry.parent, m_axis_tdata[69:38]);
                match_field("entry_level", 32'(want.entry.level),
                            32'(m_axis_tdata[85:70]));
                match_field("entry_cost", want.entry.cost, m_axis_tdata[117:86]);
                match_field("list_count", 32'(want.list_count),
                            32'(m_axis_tdata[122:118]));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        int k;
        int ph;
        int idle_by_phase  [4];
        int stall_by_phase [4];
        idle_by_phase  = '{0, 85, 0, 25};
        stall_by_phase = '{0, 0, 85, 25};
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = REQ_INSERT;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_request    = 1'b0;
        list_held       = 0;
        list_lowest     = '0;

        // directed rows: empty list, field extremes, ties, full list, clear
        add_row(make_req(REQ_READ, '0, '0, '0, '0, 4'd0), 1, plain_result(0, 0, 0));
        add_row(make_req(REQ_INSERT, '1, '1, '1, '0, 4'd15), 1, plain_result(0, 0, 0));
        add_row(make_req(REQ_UNUSED, '1, '1, '1, '1, 4'd15), 1, plain_result(0, 0, 0));
        add_row(make_req(REQ_INSERT, '1, '1, '1, '1, 4'd0), 1, plain_result(1, 0, 1));
        add_row(make_req(REQ_INSERT, '0, '0, '0, 32'd1, 4'd0), 1, plain_result(1, 1, 2));
        add_row(make_req(REQ_INSERT, 32'd1, 32'd1, 16'd1, 32'd1, 4'd0), 1,
                plain_result(1, 2, 3));
        add_row(make_req(REQ_INSERT, 32'd2, 32'd3, 16'd4, '1, 4'd0), 0, '0);
        for (k = 0; k < 12; k++)
            add_row(make_req(REQ_INSERT, 32'h100 + k, 32'h200 + k, 16'(k),
                             32'(((k * 37 + 5) % 13) * 1000 + 2), 4'd0), 0, '0);
        add_row(make_req(REQ_INSERT, 32'h55, 32'h66, 16'h77, 32'd1, 4'd0), 1,
                plain_result(0, 0, 16));
        add_row(make_req(REQ_INSERT, 32'h88, 32'h99, 16'haa, 32'h10, 4'd0), 0, '0);
        add_row(make_req(REQ_READ, '0, '0, '0, '0, 4'd15), 0, '0);
        add_row(make_req(REQ_READ, '1, '1, '1, '1, 4'd0), 0, '0);
        add_row(make_req(REQ_CLEAR, '0, '0, '0, '0, 4'd0), 1, plain_result(0, 0, 0));
        add_row(make_req(REQ_READ, '0, '0, '0, '0, 4'd0), 1, plain_result(0, 0, 0));

        // reset
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i])
            send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);

        // random phases, long receiver hold-off at the start of the first
        for (ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_by_phase[ph];
            recv_stall_pct  = stall_by_phase[ph];
            if (ph == 0)
                hold_request = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                send_req(random_req(), 1'b0, '0);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
